[src/min_max_contrast_stretch_assert.svh]
// Assertion helpers shared by the queue and back-end RTL files.
`ifndef MIN_MAX_CONTRAST_STRETCH_ASSERT_SVH
`define MIN_MAX_CONTRAST_STRETCH_ASSERT_SVH

// Check on the rising clock edge, ignored while reset is high.
`define MMCS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on the rising clock edge, also during reset.
`define MMCS_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/mmcs_pkg.sv]
package mmcs_pkg;

  // field widths
  localparam int PIX_W  = 16;
  localparam int OUT_W  = 8;
  localparam int NUM_W  = PIX_W + OUT_W;
  // quotient bits: eight result bits plus one overflow bit
  localparam int QBITS  = OUT_W + 1;
  localparam int CNT_W  = $clog2(QBITS);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [OUT_W-1:0] OUT_FULL = '1;

  // input modes
  localparam logic [1:0] MODE_MEASURE = 2'd0;
  localparam logic [1:0] MODE_STRETCH = 2'd1;
  localparam logic [1:0] MODE_RESCALE = 2'd2;

  // register indexes
  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  typedef enum logic [1:0] {
    JOB_PASS,
    JOB_ERR,
    JOB_DIV
  } job_kind_t;

  // work handed from front to back
  typedef struct packed {
    job_kind_t         kind;
    logic [NUM_W-1:0]  num;   // dividend, or pass value in the low byte
    logic [PIX_W-1:0]  den;
    logic              last;
  } job_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_ROUND
  } back_state_t;

endpackage

[src/min_max_contrast_stretch.sv]
// Channel  | Handshake            | Words
// ---------+----------------------+---------------------------------------
// input    | push / full          | mode, pixel, first, last
// result   | empty / pop          | out_pixel, frame_end, error
// config   | wr_en (no wait)      | wr_index, wr_data
//
// A measure word (mode 0) or unused mode gives no result.
// Pass-through, below-range and error words go through the job queue into the result register.
// A divided word is taken from the queue, then the back end runs 9 restoring-divide steps
// (overflow bit plus 8 quotient bits) and a rounding step that waits for a free result register.
// A two-word job queue lets input run ahead while the divider or a full
// result register stalls. Synchronous reset restores min/max and the range
// registers, empties the queue and the result register and idles the back end.
module min_max_contrast_stretch
  import mmcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [1:0]       mode,
  input  logic [PIX_W-1:0] pixel,
  input  logic             first,
  input  logic             last,
  output logic             empty,
  input  logic             pop,
  output logic [OUT_W-1:0] out_pixel,
  output logic             frame_end,
  output logic             error,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [PIX_W-1:0] wr_data
);

  logic q_full;
  logic q_empty;
  logic job_wr;
  logic q_pop;
  job_t job_in;
  job_t job_out;

  assign full = q_full;

  mmcs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .mode     (mode),
    .pixel    (pixel),
    .first    (first),
    .last     (last),
    .q_full   (q_full),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .job_wr   (job_wr),
    .job      (job_in)
  );

  mmcs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_wr),
    .wr_job  (job_in),
    .rd      (q_pop),
    .rd_job  (job_out),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  mmcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_pixel (out_pixel),
    .frame_end (frame_end),
    .error     (error)
  );

endmodule

[src/mmcs_front.sv]
module mmcs_front
  import mmcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [1:0]       mode,
  input  logic [PIX_W-1:0] pixel,
  input  logic             first,
  input  logic             last,
  input  logic             q_full,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [PIX_W-1:0] wr_data,
  output logic             job_wr,
  output job_t             job
);

  logic [PIX_W-1:0] range_low;
  logic [PIX_W-1:0] range_high;
  logic [OUT_W-1:0] frame_min;
  logic [OUT_W-1:0] frame_max;
  logic [OUT_W-1:0] frame_min_next;
  logic [OUT_W-1:0] frame_max_next;
  logic             accept;
  logic             wide;
  logic [PIX_W-1:0] lo;
  logic [PIX_W-1:0] hi;
  logic [PIX_W-1:0] diff;
  logic             scale_mode;

  assign accept = push && !q_full;
  assign wide   = |pixel[PIX_W-1:OUT_W];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= '1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RANGE_LOW:  range_low  <= wr_data;
        REG_RANGE_HIGH: range_high <= wr_data;
        default: ;
      endcase
    end
  end

  // running min/max, restarted by first
  always_comb begin
    frame_min_next = first ? OUT_FULL : frame_min;
    frame_max_next = first ? '0 : frame_max;
    if (!wide) begin
      if (pixel[OUT_W-1:0] < frame_min_next) frame_min_next = pixel[OUT_W-1:0];
      if (pixel[OUT_W-1:0] > frame_max_next) frame_max_next = pixel[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_min <= OUT_FULL;
      frame_max <= '0;
    end else if (accept && mode == MODE_MEASURE) begin
      frame_min <= frame_min_next;
      frame_max <= frame_max_next;
    end
  end

  // pick the range for the stretch or rescale
  always_comb begin
    scale_mode = 1'b0;
    lo         = range_low;
    hi         = range_high;
    unique case (mode)
      MODE_STRETCH: begin
        scale_mode = 1'b1;
        lo         = PIX_W'(frame_min);
        hi         = PIX_W'(frame_max);
      end
      MODE_RESCALE: scale_mode = 1'b1;
      default: ;
    endcase
  end

  assign diff = pixel - lo;

  // classify the word into a job for the back end
  always_comb begin
    job.kind = JOB_DIV;
    job.num  = {diff, {OUT_W{1'b0}}} - NUM_W'(diff);
    job.den  = hi - lo;
    job.last = last;
    if (mode == MODE_STRETCH && wide) begin
      job.kind = JOB_ERR;
    end else if (hi <= lo) begin
      // uniform frame passes through, empty configured range is an error
      job.kind = (mode == MODE_STRETCH) ? JOB_PASS : JOB_ERR;
      job.num  = NUM_W'(pixel[OUT_W-1:0]);
    end else if (pixel <= lo) begin
      job.kind = JOB_PASS;
      job.num  = '0;
    end
  end

  assign job_wr = accept && scale_mode;

endmodule

[src/mmcs_queue.sv]
module mmcs_queue
  import mmcs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_job,
  input  logic rd,
  output job_t rd_job,
  output logic q_full,
  output logic q_empty
);

`include "min_max_contrast_stretch_assert.svh"

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_empty = (count == '0);
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (rd) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (wr && !rd) count <= count + QCNT_W'(1);
      else if (rd && !wr) count <= count - QCNT_W'(1);
    end
  end

  `MMCS_CHECK(a_no_overflow, wr |-> (!q_full || rd), "queue written while full")
  `MMCS_CHECK(a_no_underflow, rd |-> !q_empty, "queue read while empty")
  `MMCS_CHECK(a_count_range, count <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

[src/mmcs_back.sv]
module mmcs_back
  import mmcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  job_t             job,
  input  logic             q_empty,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [OUT_W-1:0] out_pixel,
  output logic             frame_end,
  output logic             error
);

`include "min_max_contrast_stretch_assert.svh"

  back_state_t       state;
  back_state_t       state_next;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [PIX_W-1:0]  den;
  logic [QBITS-1:0]  quo;
  logic [CNT_W-1:0]  cnt;
  logic              last_r;
  logic              out_valid;
  logic              out_free;
  logic              ge;
  logic              round_up;
  logic              sat;
  logic [OUT_W-1:0]  round_val;
  logic              load_out;
  logic [OUT_W-1:0]  load_val;
  logic              load_err;
  logic              load_last;
  logic              start_div;
  logic              out_hold;
  logic [OUT_W+1:0]  out_word;
  logic              rem_ok;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign ge       = (rem >= dsh);

  // round half to even, saturate at full scale
  assign round_up  = ({rem[PIX_W-1:0], 1'b0} > {1'b0, den}) ||
                     (({rem[PIX_W-1:0], 1'b0} == {1'b0, den}) && quo[0]);
  assign sat       = quo[QBITS-1] || (round_up && quo[OUT_W-1:0] == OUT_FULL);
  assign round_val = sat ? OUT_FULL : quo[OUT_W-1:0] + OUT_W'(round_up);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (!q_empty && job.kind == JOB_DIV) state_next = S_DIV;
      S_DIV:   if (cnt == '0) state_next = S_ROUND;
      S_ROUND: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    start_div = 1'b0;
    load_out  = 1'b0;
    load_val  = '0;
    load_err  = 1'b0;
    load_last = last_r;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          if (job.kind == JOB_DIV) begin
            q_pop     = 1'b1;
            start_div = 1'b1;
          end else if (out_free) begin
            q_pop     = 1'b1;
            load_out  = 1'b1;
            load_err  = (job.kind == JOB_ERR);
            load_val  = (job.kind == JOB_ERR) ? '0 : job.num[OUT_W-1:0];
            load_last = job.last;
          end
        end
      end
      S_ROUND: begin
        load_out = out_free;
        load_val = round_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // restoring divide, one quotient bit per cycle, overflow bit first
  always_ff @(posedge clk) begin
    if (start_div) begin
      rem    <= job.num;
      dsh    <= {job.den, {OUT_W{1'b0}}};
      den    <= job.den;
      quo    <= '0;
      cnt    <= CNT_W'(QBITS - 1);
      last_r <= job.last;
    end else if (state == S_DIV) begin
      rem <= ge ? rem - dsh : rem;
      dsh <= dsh >> 1;
      quo <= {quo[QBITS-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (pop) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pixel <= load_val;
      error     <= load_err;
      frame_end <= load_last;
    end
  end

  // terms for the checks below
  assign out_hold = out_valid && !pop;
  assign out_word = {out_pixel, error, frame_end};
  assign rem_ok   = (rem < NUM_W'(den));

  `MMCS_CHECK(a_hold_result, out_hold |=> (out_valid && $stable(out_word)), "held word changed")
  `MMCS_CHECK(a_rem_below_den, (state == S_ROUND && !quo[QBITS-1]) |-> rem_ok, "bad remainder")
  `MMCS_CHECK(a_pop_only_idle, q_pop |-> (state == S_IDLE), "job taken while busy")

endmodule
